// ----- hdl/aps_pkg.sv -----
// Package for the planar array phase steering rotator.
// Register codes, configuration and pipeline structs, angle helpers.
// No dependencies.
`timescale 1ns / 1ps

package aps_pkg;

	localparam int MAX_SIDE = 4;

	// Configuration register indexes
	localparam logic [2:0] REG_STEER_MODE = 3'd0;
	localparam logic [2:0] REG_ANTS_X     = 3'd1;
	localparam logic [2:0] REG_ANTS_Y     = 3'd2;
	localparam logic [2:0] REG_SPACING_X  = 3'd3;
	localparam logic [2:0] REG_SPACING_Y  = 3'd4;
	localparam logic [2:0] REG_TABLE_LO   = 3'd5;
	localparam logic [2:0] REG_TABLE_HI   = 3'd6;

	typedef struct packed {
		logic        steer_mode;
		logic [2:0]  ants_x;
		logic [2:0]  ants_y;
		logic [9:0]  spacing_x;
		logic [9:0]  spacing_y;
		logic [63:0] table_lo;
		logic [63:0] table_hi;
	} cfg_t;

	// Direction terms handed from the front end to the sequencer
	typedef struct packed {
		logic               valid;
		logic signed [17:0] sx;
		logic signed [17:0] sy;
		logic signed [15:0] xi;
		logic signed [15:0] xq;
	} front_t;

	// One antenna issued by the sequencer
	typedef struct packed {
		logic               valid;
		logic [3:0]         idx;
		logic               last;
		logic [11:0]        mx;
		logic [11:0]        my;
		logic signed [17:0] sx;
		logic signed [17:0] sy;
		logic signed [15:0] xi;
		logic signed [15:0] xq;
	} issue_t;

	// Per-antenna data riding alongside the sine pipes
	typedef struct packed {
		logic [3:0]         idx;
		logic               last;
		logic signed [15:0] xi;
		logic signed [15:0] xq;
		logic [15:0]        ph;
	} side_t;

	typedef struct packed {
		logic               valid;
		logic [3:0]         idx;
		logic signed [15:0] out_i;
		logic signed [15:0] out_q;
		logic [15:0]        ph;
		logic               last;
	} result_t;

	// Quarter-wave argument of a binary angle (Q14, 0..16384)
	function automatic logic [14:0] ang_z(input logic [15:0] a);
		logic [14:0] r;
		r = {1'b0, a[13:0]};
		return a[14] ? (15'd16384 - r) : r;
	endfunction

	// Array side length: zero means one, clamp at MAX_SIDE
	function automatic logic [2:0] side_len(input logic [2:0] v);
		if (v == 3'd0)
			return 3'd1;
		if (v > 3'(MAX_SIDE))
			return 3'(MAX_SIDE);
		return v;
	endfunction

endpackage

// ----- hdl/aps_qsine.sv -----
// Four-stage polynomial quarter-wave sine, result Q15 with sign applied.
// Does not use aps_pkg; standalone arithmetic.
`timescale 1ns / 1ps

module aps_qsine (
	input  logic               clk,
	input  logic               en,
	input  logic [14:0]        z,
	input  logic               neg,
	output logic signed [17:0] s
);
	logic [14:0] z_s1, z_s2, z_s3;
	logic        n_s1, n_s2, n_s3;
	logic [14:0] z2_s1, z2_s2;
	logic [15:0] t1_s2;
	logic [16:0] t2_s3;
	logic [29:0] p1;
	logic [27:0] p2;
	logic [30:0] p3;
	logic [31:0] p4;
	logic [18:0] t3r;

	assign p1 = z * z;
	assign p2 = 28'(z2_s1) * 28'd4640;
	assign p3 = 31'(z2_s2) * 31'(t1_s2);
	assign p4 = 32'(z_s3) * 32'(t2_s3);
	assign t3r = {1'b0, p4[31:14]} + 19'd1;

	// z^2, then the nested Horner terms, one multiply per stage
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1  <= z;
			n_s1  <= neg;
			z2_s1 <= p1[28:14];
			z_s2  <= z_s1;
			n_s2  <= n_s1;
			z2_s2 <= z2_s1;
			t1_s2 <= 16'd42048 - {2'b00, p2[27:14]};
			z_s3  <= z_s2;
			n_s3  <= n_s2;
			t2_s3 <= 17'd102944 - p3[30:14];
			s     <= n_s3 ? -$signed({1'b0, t3r[17:1]}) : $signed({1'b0, t3r[17:1]});
		end
	end
endmodule

// ----- hdl/aps_front.sv -----
// Front end: sin(theta), cos(phi), sin(phi), then the direction terms sx, sy.
// Depends on aps_pkg and aps_qsine.
`timescale 1ns / 1ps

module aps_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_ok,
	input  logic signed [15:0] xi,
	input  logic signed [15:0] xq,
	input  logic [15:0]        theta,
	input  logic [15:0]        phi,
	output aps_pkg::front_t    f
);
	import aps_pkg::*;

	logic signed [17:0] st, cp, sp;
	logic [15:0]        phi_c;
	logic               v_s [1:4];
	logic signed [15:0] xi_s [1:4];
	logic signed [15:0] xq_s [1:4];
	logic               v_s5;
	logic signed [15:0] xi_s5, xq_s5;
	logic signed [35:0] px_s5, py_s5;
	logic signed [35:0] rx, ry;
	logic               v_s6;
	logic signed [17:0] sx_s6, sy_s6;
	logic signed [15:0] xi_s6, xq_s6;

	assign phi_c = phi + 16'h4000;

	aps_qsine u_st (.clk(clk), .en(en), .z(ang_z(theta)), .neg(theta[15]), .s(st));
	aps_qsine u_cp (.clk(clk), .en(en), .z(ang_z(phi_c)), .neg(phi_c[15]), .s(cp));
	aps_qsine u_sp (.clk(clk), .en(en), .z(ang_z(phi)),   .neg(phi[15]),   .s(sp));

	// valid line matching the sine stages, then the product and rounding stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 4; k++)
				v_s[k] <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_ok;
			for (int k = 2; k <= 4; k++)
				v_s[k] <= v_s[k-1];
			v_s5 <= v_s[4];
			v_s6 <= v_s5;
		end
	end

	// rounding: ties away from zero
	assign rx = px_s5 + 36'sd16384 - $signed({35'd0, px_s5[35]});
	assign ry = py_s5 + 36'sd16384 - $signed({35'd0, py_s5[35]});

	always_ff @(posedge clk) begin
		if (en) begin
			xi_s[1] <= xi;
			xq_s[1] <= xq;
			for (int k = 2; k <= 4; k++) begin
				xi_s[k] <= xi_s[k-1];
				xq_s[k] <= xq_s[k-1];
			end
			px_s5 <= st * cp;
			py_s5 <= st * sp;
			xi_s5 <= xi_s[4];
			xq_s5 <= xq_s[4];
			sx_s6 <= rx[32:15];
			sy_s6 <= ry[32:15];
			xi_s6 <= xi_s5;
			xq_s6 <= xq_s5;
		end
	end

	assign f = {v_s6, sx_s6, sy_s6, xi_s6, xq_s6};
endmodule

// ----- hdl/aps_back.sv -----
// Per-antenna path: phase, sine/cosine of the phase, rotation, round and saturate.
// Depends on aps_pkg and aps_qsine.
`timescale 1ns / 1ps

module aps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  aps_pkg::cfg_t    cfg,
	input  aps_pkg::issue_t  iss,
	output aps_pkg::result_t res
);
	import aps_pkg::*;

	issue_t             b1;
	logic               v_s1;
	logic               v_s2, v_s3;
	side_t              sd_s2, sd_s3;
	logic signed [30:0] px_s2, py_s2;
	logic signed [31:0] acc, accr;
	logic [63:0]        tword;
	logic [7:0]         tbyte;
	logic [15:0]        ph_c;
	logic signed [17:0] sn, cs;
	logic               v_q [4:7];
	side_t              sd_q [4:7];
	logic               v_s8;
	side_t              sd_s8;
	logic signed [33:0] ii_s8, qs_s8, is_s8, qc_s8;
	logic signed [34:0] ri, rq, rir, rqr;
	logic signed [19:0] ti, tq;
	logic               v_s9, last_s9;
	logic [3:0]         idx_s9;
	logic signed [15:0] oi_s9, oq_s9;
	logic [15:0]        ph_s9;

	// phase from direction terms, or from the table byte in table mode
	assign acc  = 32'(px_s2) + 32'(py_s2);
	assign accr = acc + 32'sd64 - $signed({31'd0, acc[31]});
	assign tword = b1.idx[3] ? cfg.table_hi : cfg.table_lo;
	assign tbyte = 8'(tword >> {b1.idx[2:0], 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int k = 4; k <= 7; k++)
				v_q[k] <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1   <= iss.valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_q[4] <= v_s3;
			for (int k = 5; k <= 7; k++)
				v_q[k] <= v_q[k-1];
			v_s8 <= v_q[7];
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b1         <= iss;
			px_s2      <= $signed({1'b0, b1.mx}) * b1.sx;
			py_s2      <= $signed({1'b0, b1.my}) * b1.sy;
			sd_s2.idx  <= b1.idx;
			sd_s2.last <= b1.last;
			sd_s2.xi   <= b1.xi;
			sd_s2.xq   <= b1.xq;
			sd_s2.ph   <= {tbyte, 8'h00};
			sd_s3.idx  <= sd_s2.idx;
			sd_s3.last <= sd_s2.last;
			sd_s3.xi   <= sd_s2.xi;
			sd_s3.xq   <= sd_s2.xq;
			sd_s3.ph   <= cfg.steer_mode ? sd_s2.ph : accr[22:7];
		end
	end

	// sine and cosine of the antenna phase
	assign ph_c = sd_s3.ph + 16'h4000;

	aps_qsine u_sn (.clk(clk), .en(en), .z(ang_z(sd_s3.ph)), .neg(sd_s3.ph[15]), .s(sn));
	aps_qsine u_cs (.clk(clk), .en(en), .z(ang_z(ph_c)),     .neg(ph_c[15]),     .s(cs));

	assign ri  = 35'(ii_s8) - 35'(qs_s8);
	assign rq  = 35'(is_s8) + 35'(qc_s8);
	assign rir = ri + 35'sd16384 - $signed({34'd0, ri[34]});
	assign rqr = rq + 35'sd16384 - $signed({34'd0, rq[34]});
	assign ti  = rir[34:15];
	assign tq  = rqr[34:15];

	// rotation products, then round and saturate into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[4] <= sd_s3;
			for (int k = 5; k <= 7; k++)
				sd_q[k] <= sd_q[k-1];
			sd_s8 <= sd_q[7];
			ii_s8 <= sd_q[7].xi * cs;
			qs_s8 <= sd_q[7].xq * sn;
			is_s8 <= sd_q[7].xi * sn;
			qc_s8 <= sd_q[7].xq * cs;
			idx_s9  <= sd_s8.idx;
			ph_s9   <= sd_s8.ph;
			last_s9 <= sd_s8.last;
			if (ti > 20'sd32767)
				oi_s9 <= 16'sh7fff;
			else if (ti < -20'sd32768)
				oi_s9 <= 16'sh8000;
			else
				oi_s9 <= ti[15:0];
			if (tq > 20'sd32767)
				oq_s9 <= 16'sh7fff;
			else if (tq < -20'sd32768)
				oq_s9 <= 16'sh8000;
			else
				oq_s9 <= tq[15:0];
		end
	end

	assign res = {v_s9, idx_s9, oi_s9, oq_s9, ph_s9, last_s9};
endmodule

// ----- hdl/array_phase_steer_rotator_core.sv -----
// Top level: configuration registers, antenna sequencer, front end and back end.
// Depends on aps_pkg, aps_front, aps_back.
//
//  channel | signals                                        | direction
//  input   | in_valid/in_stall, sample_i/q, steer_theta/phi | in, stall out
//  output  | out_valid/out_stall, antenna_index, out_i/q,   | out, stall in
//          | phase, last                                    |
//  config  | cfg_we, cfg_index, cfg_data                    | in
//
// One sample yields ants_x*ants_y results after clamping (1..16), one per cycle
// while the output is not stalled; a new sample is taken as the sequencer issues
// its final antenna, so samples overlap in the pipeline.
// Reset clears all valid bits and loads the register defaults.
// A held output stalls every stage together; the front end also waits while
// the sequencer is busy with the previous sample.
`timescale 1ns / 1ps

module array_phase_steer_rotator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_i,
	input  logic signed [15:0] sample_q,
	input  logic signed [15:0] steer_theta,
	input  logic signed [15:0] steer_phi,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         antenna_index,
	output logic signed [15:0] out_i,
	output logic signed [15:0] out_q,
	output logic [15:0]        phase,
	output logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import aps_pkg::*;

	cfg_t    cfg_q;
	front_t  f;
	issue_t  iss;
	result_t res;
	logic    en, fen, seq_free, seq_last, load;
	logic    busy_q;
	logic [1:0] kx_q, ky_q;
	logic [2:0] nx, ny;
	logic signed [17:0] sx_q, sy_q;
	logic signed [15:0] xi_q, xq_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_mode <= 1'b0;
			cfg_q.ants_x     <= 3'd4;
			cfg_q.ants_y     <= 3'd4;
			cfg_q.spacing_x  <= 10'd128;
			cfg_q.spacing_y  <= 10'd128;
			cfg_q.table_lo   <= 64'd0;
			cfg_q.table_hi   <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEER_MODE: cfg_q.steer_mode <= cfg_data[0];
				REG_ANTS_X:     cfg_q.ants_x     <= cfg_data[2:0];
				REG_ANTS_Y:     cfg_q.ants_y     <= cfg_data[2:0];
				REG_SPACING_X:  cfg_q.spacing_x  <= cfg_data[9:0];
				REG_SPACING_Y:  cfg_q.spacing_y  <= cfg_data[9:0];
				REG_TABLE_LO:   cfg_q.table_lo   <= cfg_data;
				REG_TABLE_HI:   cfg_q.table_hi   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stall control
	assign en       = !res.valid || !out_stall;
	assign nx       = side_len(cfg_q.ants_x);
	assign ny       = side_len(cfg_q.ants_y);
	assign seq_last = ({1'b0, kx_q} == nx - 3'd1) && ({1'b0, ky_q} == ny - 3'd1);
	assign seq_free = !busy_q || (en && seq_last);
	assign fen      = en && seq_free;
	assign in_stall = !fen;
	assign load     = fen && f.valid;

	aps_front u_front (
		.clk(clk), .arst_n(arst_n), .en(fen), .in_ok(in_valid),
		.xi(sample_i), .xq(sample_q), .theta(steer_theta), .phi(steer_phi), .f(f)
	);

	// antenna sequencer, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kx_q   <= 2'd0;
			ky_q   <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			kx_q   <= 2'd0;
			ky_q   <= 2'd0;
		end else if (en && busy_q) begin
			if (seq_last) begin
				busy_q <= 1'b0;
			end else if ({1'b0, kx_q} == nx - 3'd1) begin
				kx_q <= 2'd0;
				ky_q <= ky_q + 2'd1;
			end else begin
				kx_q <= kx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sx_q <= f.sx;
			sy_q <= f.sy;
			xi_q <= f.xi;
			xq_q <= f.xq;
		end
	end

	always_comb begin
		iss.valid = busy_q;
		iss.idx   = 4'(ky_q) * 4'(nx) + 4'(kx_q);
		iss.last  = seq_last;
		iss.mx    = 12'(kx_q) * 12'(cfg_q.spacing_x);
		iss.my    = 12'(ky_q) * 12'(cfg_q.spacing_y);
		iss.sx    = sx_q;
		iss.sy    = sy_q;
		iss.xi    = xi_q;
		iss.xq    = xq_q;
	end

	aps_back u_back (.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q), .iss(iss), .res(res));

	assign out_valid     = res.valid;
	assign antenna_index = res.idx;
	assign out_i         = res.out_i;
	assign out_q         = res.out_q;
	assign phase         = res.ph;
	assign last          = res.last;
endmodule

// ----- sim/array_phase_steer_rotator_core_tb.sv -----
// Testbench for array_phase_steer_rotator_core: directed and random samples in
// steering and table modes, checked per antenna by a scoreboard. Depends on aps_pkg.
`timescale 1ns / 1ps

module array_phase_steer_rotator_core_tb;
	import aps_pkg::*;

	// Expected antenna result
	typedef struct packed {
		logic [3:0]  idx;
		logic [15:0] ri;
		logic [15:0] rq;
		logic [15:0] ph;
		logic        lst;
	} ant_res_t;

	// Scoreboard: holds the beam model state and the pending antenna results
	class beam_scoreboard;
		ant_res_t    pending[$];
		int          errors;
		logic        mode;
		logic [2:0]  nx_reg, ny_reg;
		logic [9:0]  dx, dy;
		logic [63:0] tab_lo, tab_hi;

		function new();
			errors = 0;
			mode = 0; nx_reg = 4; ny_reg = 4; dx = 128; dy = 128;
			tab_lo = 0; tab_hi = 0;
		endfunction

		function void write_reg(logic [2:0] ix, logic [63:0] v);
			case (ix)
				REG_STEER_MODE: mode = v[0];
				REG_ANTS_X:     nx_reg = v[2:0];
				REG_ANTS_Y:     ny_reg = v[2:0];
				REG_SPACING_X:  dx = v[9:0];
				REG_SPACING_Y:  dy = v[9:0];
				REG_TABLE_LO:   tab_lo = v;
				REG_TABLE_HI:   tab_hi = v;
				default: ;
			endcase
		endfunction

		static function longint rnd(longint v, int n);
			longint h;
			h = longint'(1) << (n - 1);
			return (v >= 0) ? ((v + h) >>> n) : -((-v + h) >>> n);
		endfunction

		static function longint quart(longint z);
			longint z2, t;
			z2 = (z * z) >>> 14;
			t = 42048 - ((4640 * z2) >>> 14);
			t = 102944 - ((z2 * t) >>> 14);
			t = (z * t) >>> 14;
			return (t + 1) >>> 1;
		endfunction

		static function longint sine(logic [15:0] a);
			longint s;
			s = a[14] ? quart(16384 - longint'(a[13:0])) : quart(longint'(a[13:0]));
			return a[15] ? -s : s;
		endfunction

		static function longint sat(longint v);
			return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
		endfunction

		static function int clamp_side(logic [2:0] v);
			return (v == 0) ? 1 : ((v > MAX_SIDE) ? MAX_SIDE : int'(v));
		endfunction

		// Expand one accepted sample into its antenna results
		function void note_sample(logic signed [15:0] xi, logic signed [15:0] xq,
				logic [15:0] th, logic [15:0] phi);
			int nx, ny, total, k;
			longint st, sx, sy, acc, c, s;
			logic [15:0] ph;
			ant_res_t r;
			nx = clamp_side(nx_reg);
			ny = clamp_side(ny_reg);
			total = (nx * ny > 16) ? 16 : nx * ny;
			st = sine(th);
			sx = rnd(st * sine(phi + 16'd16384), 15);
			sy = rnd(st * sine(phi), 15);
			for (k = 0; k < total; k++) begin
				if (mode)
					ph = {(k < 8) ? tab_lo[(k%8)*8 +: 8] : tab_hi[(k%8)*8 +: 8], 8'd0};
				else begin
					acc = longint'(k % nx) * dx * sx + longint'(k / nx) * dy * sy;
					ph = 16'(rnd(acc, 7));
				end
				c = sine(ph + 16'd16384);
				s = sine(ph);
				r.idx = 4'(k);
				r.ri = 16'(sat(rnd(longint'(xi) * c - longint'(xq) * s, 15)));
				r.rq = 16'(sat(rnd(longint'(xi) * s + longint'(xq) * c, 15)));
				r.ph = ph;
				r.lst = (k + 1 == total);
				pending.push_back(r);
			end
		endfunction

		function void check_result(ant_res_t got);
			ant_res_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result exp none act %h", $time, got);
				return;
			end
			e = pending.pop_front();
			if (got.idx !== e.idx) begin
				errors++;
				$display("%0t: antenna_index exp %0d act %0d", $time, e.idx, got.idx);
			end
			if (got.ri !== e.ri) begin
				errors++;
				$display("%0t: out_i exp %h act %h", $time, e.ri, got.ri);
			end
			if (got.rq !== e.rq) begin
				errors++;
				$display("%0t: out_q exp %h act %h", $time, e.rq, got.rq);
			end
			if (got.ph !== e.ph) begin
				errors++;
				$display("%0t: phase exp %h act %h", $time, e.ph, got.ph);
			end
			if (got.lst !== e.lst) begin
				errors++;
				$display("%0t: last exp %b act %b", $time, e.lst, got.lst);
			end
		endfunction
	endclass

	logic               clk, arst_n;
	logic               in_valid, in_stall;
	logic signed [15:0] sample_i, sample_q, steer_theta, steer_phi;
	logic               out_valid, out_stall;
	logic [3:0]         antenna_index;
	logic signed [15:0] out_i, out_q;
	logic [15:0]        phase;
	logic               last;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;

	beam_scoreboard sb;
	bit             hold_off;     // long receiver hold-off request
	longint         cycles;

	array_phase_steer_rotator_core dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Output side: random stalls, plus a long hold-off on request
	initial begin
		int gap, k;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_stall <= 1;
				for (k = 0; k < 300; k++) @(posedge clk);
				hold_off = 0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
			if ($urandom_range(0, 1)) gap = 0;
			out_stall <= (gap != 0);
			for (k = 0; k < gap; k++) @(posedge clk);
			out_stall <= 0;
			@(posedge clk);
		end
	end

	// Result checking at the edge
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result({antenna_index, out_i, out_q, phase, last});

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 2000000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_sample(logic [15:0] si, logic [15:0] sq, logic [15:0] th,
			logic [15:0] ph, bit idle);
		int gap;
		gap = idle ? int'($urandom_range(0, 16)) : 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		sample_i <= si; sample_q <= sq; steer_theta <= th; steer_phi <= ph;
		do @(posedge clk); while (in_stall);
		sb.note_sample(si, sq, th, ph);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] ix, logic [63:0] v);
		cfg_we <= 1; cfg_index <= ix; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(ix, v);
	endtask

	task automatic random_set(int n, bit idle);
		int k;
		logic [15:0] a, b;
		for (k = 0; k < n; k++) begin
			a = 16'($urandom); b = 16'($urandom);
			if ($urandom_range(0, 9) == 0) a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			send_sample(16'($urandom), 16'($urandom), a, b, idle);
		end
	endtask

	initial begin
		int p;
		logic [15:0] ext[4];
		sb = new();
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		arst_n = 0; in_valid = 0; sample_i = 0; sample_q = 0; steer_theta = 0;
		steer_phi = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0; hold_off = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes at reset configuration, quadrant angles
		foreach (ext[i]) send_sample(ext[i], ext[3 - i], 16'h4000, ext[i], 0);
		send_sample(16'h7fff, 16'h7fff, 16'h4000, 16'h2000, 0);
		send_sample(16'h8000, 16'h8000, 16'hc000, 16'h6000, 0);
		send_sample(16'h1234, 16'hedcb, 16'h0000, 16'h0000, 0);
		drain();
		// Zero sides, max spacing
		write_cfg(REG_ANTS_X, 0); write_cfg(REG_ANTS_Y, 0);
		write_cfg(REG_SPACING_X, 1023); write_cfg(REG_SPACING_Y, 1023);
		send_sample(16'h7fff, 16'h0000, 16'h4000, 16'h0000, 0);
		drain();
		write_cfg(REG_ANTS_X, 4); write_cfg(REG_ANTS_Y, 1);
		send_sample(16'h8000, 16'h7fff, 16'h4000, 16'h0000, 0);
		send_sample(16'h7fff, 16'h8000, 16'h2000, 16'h4000, 0);
		drain();
		// Table mode, all entries, side above limit
		write_cfg(REG_STEER_MODE, 1);
		write_cfg(REG_TABLE_LO, 64'hffe0_c080_4020_0100);
		write_cfg(REG_TABLE_HI, 64'h7f3f_1f0f_0703_01ff);
		write_cfg(REG_ANTS_X, 7); write_cfg(REG_ANTS_Y, 7);
		send_sample(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 0);
		send_sample(16'h8000, 16'h8000, 16'h0000, 16'h0000, 0);
		send_sample(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 0);
		drain();

		// Random phases over several configurations
		for (p = 0; p < 10; p++) begin
			write_cfg(REG_STEER_MODE, 64'($urandom_range(0, 1)));
			write_cfg(REG_ANTS_X, 64'($urandom_range(0, 7)));
			write_cfg(REG_ANTS_Y, 64'($urandom_range(0, 7)));
			write_cfg(REG_SPACING_X, (p == 0) ? 64'd0 : 64'($urandom_range(0, 1023)));
			write_cfg(REG_SPACING_Y, (p == 1) ? 64'd1023 : 64'($urandom_range(0, 1023)));
			write_cfg(REG_TABLE_LO, {$urandom, $urandom});
			write_cfg(REG_TABLE_HI, {$urandom, $urandom});
			if (p == 3) begin
				// Long hold-off while samples keep coming
				hold_off = 1;
				random_set(30, 0);
			end else
				random_set(30, p % 3 != 2);
			drain();
		end
		random_set(15, 1);
		drain();

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
